>>> rtl/quadtree_morton_cell_index_unit_assert.svh
// ----------------------------------------------------------------------------
// Quadtree Morton cell index assertion macros
// Shorthand for clocked assertions with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef QUADTREE_MORTON_CELL_INDEX_UNIT_ASSERT_SVH
`define QUADTREE_MORTON_CELL_INDEX_UNIT_ASSERT_SVH

// Same-cycle implication.
`define QMCI_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define QMCI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/qmci_pkg.sv
// ----------------------------------------------------------------------------
// Quadtree Morton cell index package
// Shared widths, register indexes, result type and level-size table.
// ----------------------------------------------------------------------------
package qmci_pkg;

  localparam int QMCI_MAX_DEPTH = 8;
  localparam int COORD_W        = 32;
  localparam int DEPTH_W        = 4;
  localparam int INDEX_W        = 17;
  localparam int CFG_IDX_W      = 3;
  localparam int S_TDATA_W      = 4 * COORD_W;
  localparam int M_TDATA_W      = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X   = 3'd0,
    REG_ORIGIN_Y   = 3'd1,
    REG_SCALE_X    = 3'd2,
    REG_SCALE_Y    = 3'd3,
    REG_TREE_DEPTH = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic               index_valid;
    logic [DEPTH_W-1:0] cell_depth;
    logic [INDEX_W-1:0] cell_index;
  } qmci_result_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

  // Number of cells in all levels above level n, that is (4^n - 1) / 3.
  localparam logic [INDEX_W-1:0] TREE_CELLS [16] = '{
    17'd0, 17'd1, 17'd5, 17'd21, 17'd85, 17'd341, 17'd1365, 17'd5461,
    17'd21845, 17'd87381, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0
  };

endpackage

>>> rtl/qmci_corner_map.sv
// ----------------------------------------------------------------------------
// Corner to grid cell mapper
// Three stages: origin offset, Q16.16 scale multiply, range check.
// ----------------------------------------------------------------------------
module qmci_corner_map import qmci_pkg::*; #(
  parameter int CELL_W = QMCI_MAX_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  stage_en_t          en_i,
  input  logic [COORD_W-1:0] coord_i,
  input  logic [COORD_W-1:0] origin_i,
  input  logic [COORD_W-1:0] scale_i,
  input  logic [DEPTH_W-1:0] depth_i,
  output logic [CELL_W-1:0]  cell_o,
  output logic               inside_o
);

  logic [COORD_W:0]     diff_d, diff_q;
  logic [2*COORD_W-1:0] prod;
  logic [COORD_W-1:0]   prod_hi_q;
  logic                 neg_q;
  logic [CELL_W-1:0]    cell_q;
  logic                 inside_d, inside_q;

  assign diff_d   = {coord_i[COORD_W-1], coord_i} - {origin_i[COORD_W-1], origin_i};
  assign prod     = diff_q[COORD_W-1:0] * scale_i;
  assign inside_d = !neg_q && ((prod_hi_q >> depth_i) == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neg_q    <= 1'b0;
      inside_q <= 1'b0;
    end else begin
      if (en_i.s2) begin
        neg_q <= diff_q[COORD_W];
      end
      if (en_i.s3) begin
        inside_q <= inside_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s1) begin
      diff_q <= diff_d;
    end
    if (en_i.s2) begin
      prod_hi_q <= prod[2*COORD_W-1:COORD_W];
    end
    if (en_i.s3) begin
      cell_q <= prod_hi_q[CELL_W-1:0];
    end
  end

  assign cell_o   = cell_q;
  assign inside_o = inside_q;

endmodule

>>> rtl/qmci_cell_index.sv
// ----------------------------------------------------------------------------
// Morton level and linear index stage
// Interleaves corner cells, finds the shared level and forms the index.
// ----------------------------------------------------------------------------
module qmci_cell_index import qmci_pkg::*; #(
  parameter int CELL_W = QMCI_MAX_DEPTH
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [CELL_W-1:0]  lx_i,
  input  logic [CELL_W-1:0]  ty_i,
  input  logic [CELL_W-1:0]  rx_i,
  input  logic [CELL_W-1:0]  by_i,
  input  logic               inside_i,
  input  logic [DEPTH_W-1:0] depth_i,
  output qmci_result_t       result_o
);

  localparam int MORTON_W = 2 * CELL_W;

  logic [MORTON_W-1:0] lt, rb, diff, space;
  logic [DEPTH_W-1:0]  hi, level;
  logic [INDEX_W:0]    sum;
  logic [INDEX_W-1:0]  base, cells;
  qmci_result_t        result_d, result_q;

  always_comb begin
    for (int i = 0; i < CELL_W; i++) begin
      lt[2*i]   = lx_i[i];
      lt[2*i+1] = ty_i[i];
      rb[2*i]   = rx_i[i];
      rb[2*i+1] = by_i[i];
    end
    diff = lt ^ rb;
    hi   = '0;
    for (int i = 0; i < CELL_W; i++) begin
      if ((DEPTH_W'(i) < depth_i) && (diff[2*i +: 2] != 2'b00)) begin
        hi = DEPTH_W'(i + 1);
      end
    end
    space = rb >> {hi, 1'b0};
    level = depth_i - hi;
    base  = TREE_CELLS[level];
    cells = TREE_CELLS[depth_i + DEPTH_W'(1)];
    sum   = {1'b0, INDEX_W'(space)} + {1'b0, base};
    result_d = '0;
    if (inside_i && (sum < {1'b0, cells})) begin
      result_d.index_valid = 1'b1;
      result_d.cell_depth  = level;
      result_d.cell_index  = sum[INDEX_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      result_q <= result_d;
    end
  end

  assign result_o = result_q;

endmodule

>>> rtl/quadtree_morton_cell_index_unit.sv
// ----------------------------------------------------------------------------
// Quadtree Morton cell index unit
// Maps a Q16.16 bounding box to its linear quadtree cell index.
// ----------------------------------------------------------------------------
// Boxes enter on the s_axis channel as left, top, right and bottom corners.
// Each result leaves on the m_axis channel with the cell index, cell depth
// and a valid flag; a box with a corner outside the grid gives all zeros.
// The area origin, scale factors and tree depth are set through the plain
// write port and must only change while no item is in flight.
// The unit takes one item every cycle while the receiver does not stall.
// The four register stages are origin offset, the 32 by 32 scale multiply,
// the grid range check, and the Morton level search with index forming,
// whose register holds the result. When the receiver stalls, the result
// holds and empty stages still fill, so up to four items are held before
// s_axis_tready falls. Reset empties the pipeline and loads the default
// configuration.
// ----------------------------------------------------------------------------
module quadtree_morton_cell_index_unit import qmci_pkg::*; #(
  parameter int MAX_DEPTH = QMCI_MAX_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COORD_W-1:0]   cfg_data_i,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // box_left, box_top, box_right, box_bottom
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // cell_index, cell_depth, index_valid, zero fill
  output logic [M_TDATA_W-1:0] m_axis_tdata
);

  logic [COORD_W-1:0] origin_x_q, origin_y_q, scale_x_q, scale_y_q;
  logic [DEPTH_W-1:0] tree_depth_q, depth_eff;
  logic [3:0]         valid_q;
  stage_en_t          en;
  logic [MAX_DEPTH-1:0] lx, ty, rx, by;
  logic [3:0]         corner_in;
  qmci_result_t       result;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q   <= '0;
      origin_y_q   <= '0;
      scale_x_q    <= 32'h0001_0000;
      scale_y_q    <= 32'h0001_0000;
      tree_depth_q <= 4'd3;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ORIGIN_X:   origin_x_q   <= cfg_data_i;
        REG_ORIGIN_Y:   origin_y_q   <= cfg_data_i;
        REG_SCALE_X:    scale_x_q    <= cfg_data_i;
        REG_SCALE_Y:    scale_y_q    <= cfg_data_i;
        REG_TREE_DEPTH: tree_depth_q <= cfg_data_i[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (tree_depth_q == '0) begin
      depth_eff = DEPTH_W'(1);
    end else if (tree_depth_q > DEPTH_W'(MAX_DEPTH)) begin
      depth_eff = DEPTH_W'(MAX_DEPTH);
    end else begin
      depth_eff = tree_depth_q;
    end
  end

  // A stage loads when it is empty or the stage after it moves on.
  assign en.s4 = !valid_q[3] || m_axis_tready;
  assign en.s3 = !valid_q[2] || en.s4;
  assign en.s2 = !valid_q[1] || en.s3;
  assign en.s1 = !valid_q[0] || en.s2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en.s1) valid_q[0] <= s_axis_tvalid;
      if (en.s2) valid_q[1] <= valid_q[0];
      if (en.s3) valid_q[2] <= valid_q[1];
      if (en.s4) valid_q[3] <= valid_q[2];
    end
  end

  qmci_corner_map #(.CELL_W(MAX_DEPTH)) u_left (
    .clk_i, .rst_ni, .en_i(en),
    .coord_i(s_axis_tdata[0*COORD_W +: COORD_W]), .origin_i(origin_x_q),
    .scale_i(scale_x_q), .depth_i(depth_eff), .cell_o(lx), .inside_o(corner_in[0])
  );

  qmci_corner_map #(.CELL_W(MAX_DEPTH)) u_top (
    .clk_i, .rst_ni, .en_i(en),
    .coord_i(s_axis_tdata[1*COORD_W +: COORD_W]), .origin_i(origin_y_q),
    .scale_i(scale_y_q), .depth_i(depth_eff), .cell_o(ty), .inside_o(corner_in[1])
  );

  qmci_corner_map #(.CELL_W(MAX_DEPTH)) u_right (
    .clk_i, .rst_ni, .en_i(en),
    .coord_i(s_axis_tdata[2*COORD_W +: COORD_W]), .origin_i(origin_x_q),
    .scale_i(scale_x_q), .depth_i(depth_eff), .cell_o(rx), .inside_o(corner_in[2])
  );

  qmci_corner_map #(.CELL_W(MAX_DEPTH)) u_bottom (
    .clk_i, .rst_ni, .en_i(en),
    .coord_i(s_axis_tdata[3*COORD_W +: COORD_W]), .origin_i(origin_y_q),
    .scale_i(scale_y_q), .depth_i(depth_eff), .cell_o(by), .inside_o(corner_in[3])
  );

  qmci_cell_index #(.CELL_W(MAX_DEPTH)) u_index (
    .clk_i,
    .en_i(en.s4),
    .lx_i(lx), .ty_i(ty), .rx_i(rx), .by_i(by),
    .inside_i(&corner_in),
    .depth_i(depth_eff),
    .result_o(result)
  );

  assign s_axis_tready = en.s1;
  assign m_axis_tvalid = valid_q[3];
  assign m_axis_tdata  = {2'b00, result.index_valid, result.cell_depth, result.cell_index};

endmodule

>>> rtl/qmci_checker.sv
// ----------------------------------------------------------------------------
// Quadtree Morton cell index port checker
// Watches the top-level ports for result and flow-control consistency.
// ----------------------------------------------------------------------------
`include "quadtree_morton_cell_index_unit_assert.svh"

module qmci_checker import qmci_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata
);

  `QMCI_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata))

  `QMCI_ASSERT_IMPL(a_invalid_zero, m_axis_tvalid && !m_axis_tdata[21],
    m_axis_tdata[20:0] == 21'd0)

  `QMCI_ASSERT_IMPL(a_root_index,
    m_axis_tvalid && m_axis_tdata[21] && (m_axis_tdata[20:17] == 4'd0),
    m_axis_tdata[16:0] == 17'd0)

  `QMCI_ASSERT_IMPL(a_ready_when_empty, !m_axis_tvalid, s_axis_tready)

endmodule

bind quadtree_morton_cell_index_unit qmci_checker u_qmci_checker (.*);
